// ===== rtl/shli_pkg.sv =====
// ---------------------------------------------------------------------------
// shli_pkg - shared definitions for the symbol hash lookup/insert block
// Constants of the name hash and probe sequence, result codes and the
// name trimming and byte mixing functions.
// ---------------------------------------------------------------------------
package shli_pkg;

  // Default bucket table / name store depth
  localparam int TABLE_DEPTH_DEF = 1024;

  // Hash constants
  localparam int HASH_MUL     = 21;
  localparam int HASH_ADD     = 8521;
  localparam int HASH_W       = 15;      // mask 077777 keeps 15 bits
  localparam int PROBE_STRIDE = 17;

  // Field widths
  localparam int NAME_W  = 64;
  localparam int ENTRY_W = 10;
  localparam int MIX_W   = 12;

  // Result codes
  typedef enum logic [1:0] {
    ST_FOUND    = 2'd0,
    ST_INSERTED = 2'd1,
    ST_OVERFLOW = 2'd2
  } status_t;

  // Zero every byte from the first zero byte on
  function automatic logic [NAME_W-1:0] shli_trim(input logic [NAME_W-1:0] raw);
    logic [NAME_W-1:0] res;
    logic              ended;
    res   = '0;
    ended = 1'b0;
    for (int i = 0; i < 8; i++) begin
      if (raw[8*i +: 8] == 8'd0) begin
        ended = 1'b1;
      end
      if (!ended) begin
        res[8*i +: 8] = raw[8*i +: 8];
      end
    end
    return res;
  endfunction

  // Combine the eight name bytes before the multiply
  function automatic logic [MIX_W-1:0] shli_mix(input logic [NAME_W-1:0] nm);
    logic [8:0] sum03;
    logic [7:0] x17;
    logic [7:0] x245;
    sum03 = {1'b0, nm[7:0]} + {1'b0, nm[31:24]};
    x17   = nm[15:8] ^ nm[63:56];
    x245  = nm[23:16] ^ nm[39:32] ^ nm[47:40];
    return {sum03, 3'b000}
         | {4'b0000, x17}
         | {3'b000, x245, 1'b0}
         | {2'b00, nm[55:48], 2'b00};
  endfunction

endpackage

// ===== rtl/shli_ram.sv =====
// ---------------------------------------------------------------------------
// shli_ram - generic single-port-write, single-port-read RAM
// One write and one read per cycle, read data registered.
// ---------------------------------------------------------------------------
module shli_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/symbol_hash_lookup_insert_top.sv =====
// ---------------------------------------------------------------------------
// symbol_hash_lookup_insert_top - symbol table lookup and insert
// Open-addressing hash table over a name store, probed in strides of 17.
// ---------------------------------------------------------------------------
// After reset the block sweeps the bucket table clear, one bucket a cycle,
// and in_tready stays low until the sweep ends. Then it takes one name beat
// at a time and is not ready until that beat's result sits in the output
// register (a new beat may be taken while that result still waits). An
// ordinary name is taken and hashed, then reduced to a bucket one quotient
// bit per cycle when TABLE_DEPTH is not a power of two (no reduction step
// otherwise). Each bucket whose entry is compared takes a bucket RAM read, a
// name RAM read and a compare; an empty bucket ends the search after its
// bucket RAM read. A name not found is then appended, and the result is
// handed over. A temporary name skips the hash and the probes and goes
// straight to the append. The hand-over stalls while the previous result
// still waits in the output register. The probe loop through the two
// registered RAMs sets the per-probe cost; one shared compare-subtract unit
// does both the bucket reduction and the stride wrap.
// ---------------------------------------------------------------------------
module symbol_hash_lookup_insert_top #(
  parameter int TABLE_DEPTH = shli_pkg::TABLE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // input beats
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // [63:0] symbol_name
  input  logic [0:0]  in_tuser,   // [0] is_temporary
  // result beats
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata   // [9:0] entry_index, [11:10] status, [15:12] zero
);

  import shli_pkg::*;

  localparam int  IDX_W     = $clog2(TABLE_DEPTH);
  localparam int  U_W       = 16;
  localparam bit  POW2      = (TABLE_DEPTH & (TABLE_DEPTH - 1)) == 0;
  localparam int  MOD_STEPS = $clog2((32768 + TABLE_DEPTH - 1) / TABLE_DEPTH);
  localparam int  MOD_SHIFT = (MOD_STEPS > 0) ? MOD_STEPS - 1 : 0;
  localparam int  MCNT_W    = (MOD_STEPS > 1) ? $clog2(MOD_STEPS) : 1;
  localparam logic [U_W-1:0]    DIV_INIT  = U_W'(TABLE_DEPTH << MOD_SHIFT);
  localparam logic [MCNT_W-1:0] MCNT_INIT = MCNT_W'((MOD_STEPS > 0) ? MOD_STEPS - 1 : 0);
  localparam logic [IDX_W-1:0]  LAST_IDX  = IDX_W'(TABLE_DEPTH - 1);
  localparam logic [IDX_W:0]    PROBE_MAX = (IDX_W + 1)'(TABLE_DEPTH);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_HASH, S_MOD, S_PROBE, S_LINK, S_CMP, S_INSERT, S_RESP
  } state_t;

  state_t              state_r;
  logic [NAME_W-1:0]   name_r;
  logic                temp_r;
  logic [U_W-1:0]      h_r;
  logic [U_W-1:0]      div_r;
  logic [MCNT_W-1:0]   mcnt_r;
  logic [IDX_W-1:0]    slot_r;
  logic [IDX_W:0]      pcnt_r;
  logic [IDX_W-1:0]    nfree_r;
  logic [IDX_W-1:0]    clr_r;
  logic [IDX_W-1:0]    res_idx_r;
  status_t             res_st_r;
  logic                out_tvalid_r;
  logic [15:0]         out_tdata_r;

  logic [IDX_W:0]      pcnt_nxt;
  logic [31:0]         res_idx_ext;
  logic [16:0]         hash_prod;
  logic                full;

  // shared compare-subtract unit
  logic [U_W-1:0]      u_a;
  logic [U_W-1:0]      u_b;
  logic [U_W-1:0]      u_res;

  // memory ports
  logic                bkt_we;
  logic [IDX_W-1:0]    bkt_waddr;
  logic [IDX_W-1:0]    bkt_wdata;
  logic [IDX_W-1:0]    bkt_rdata;
  logic                nm_we;
  logic [IDX_W-1:0]    nm_raddr;
  logic [NAME_W-1:0]   nm_rdata;

  // Select operands: quotient bit during reduction, stride wrap otherwise
  always_comb begin
    if (state_r == S_MOD) begin
      u_a = h_r;
      u_b = div_r;
    end else begin
      u_a = U_W'(slot_r) + U_W'(PROBE_STRIDE);
      u_b = U_W'(TABLE_DEPTH);
    end
    u_res = (u_a >= u_b) ? (u_a - u_b) : u_a;
  end

  assign hash_prod = 17'(shli_mix(name_r)) * 17'(HASH_MUL) + 17'(HASH_ADD);
  assign full      = (nfree_r == LAST_IDX);
  assign pcnt_nxt  = pcnt_r + 1'b1;

  // Drive bucket and name RAM ports
  always_comb begin
    bkt_we    = (state_r == S_CLEAR) || (state_r == S_INSERT && !temp_r && !full);
    bkt_waddr = (state_r == S_CLEAR) ? clr_r : slot_r;
    bkt_wdata = (state_r == S_CLEAR) ? '0 : nfree_r + 1'b1;
    nm_we     = (state_r == S_INSERT) && !full;
    nm_raddr  = bkt_rdata - 1'b1;
  end

  shli_ram #(
    .WIDTH (IDX_W),
    .DEPTH (TABLE_DEPTH)
  ) u_bucket_ram (
    .clk     (clk),
    .wr_en   (bkt_we),
    .wr_addr (bkt_waddr),
    .wr_data (bkt_wdata),
    .rd_addr (slot_r),
    .rd_data (bkt_rdata)
  );

  shli_ram #(
    .WIDTH (NAME_W),
    .DEPTH (TABLE_DEPTH)
  ) u_name_ram (
    .clk     (clk),
    .wr_en   (nm_we),
    .wr_addr (nfree_r),
    .wr_data (name_r),
    .rd_addr (nm_raddr),
    .rd_data (nm_rdata)
  );

  assign res_idx_ext = 32'(res_idx_r);

  // Sequencer: state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      clr_r        <= '0;
      nfree_r      <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      // drop the result beat once taken, unless a new one replaces it
      if (out_tvalid_r && out_tready && state_r != S_RESP) begin
        out_tvalid_r <= 1'b0;
      end

      unique case (state_r)
        S_CLEAR: begin
          clr_r <= clr_r + 1'b1;
          if (clr_r == LAST_IDX) begin
            state_r <= S_IDLE;
          end
        end

        S_IDLE: begin
          if (in_tvalid) begin
            name_r  <= shli_trim(in_tdata);
            temp_r  <= in_tuser[0];
            state_r <= in_tuser[0] ? S_INSERT : S_HASH;
          end
        end

        S_HASH: begin
          h_r    <= {1'b0, hash_prod[HASH_W-1:0]};
          div_r  <= DIV_INIT;
          mcnt_r <= MCNT_INIT;
          pcnt_r <= '0;
          if (POW2) begin
            slot_r  <= hash_prod[IDX_W-1:0];
            state_r <= S_PROBE;
          end else begin
            state_r <= S_MOD;
          end
        end

        // one quotient bit of the bucket reduction per cycle
        S_MOD: begin
          h_r   <= u_res;
          div_r <= div_r >> 1;
          if (mcnt_r == '0) begin
            slot_r  <= u_res[IDX_W-1:0];
            state_r <= S_PROBE;
          end else begin
            mcnt_r <= mcnt_r - 1'b1;
          end
        end

        S_PROBE: begin
          state_r <= S_LINK;
        end

        // empty bucket ends the search, else fetch the linked name
        S_LINK: begin
          if (bkt_rdata == '0) begin
            state_r <= S_INSERT;
          end else begin
            res_idx_r <= nm_raddr;
            state_r   <= S_CMP;
          end
        end

        S_CMP: begin
          if (nm_rdata == name_r) begin
            res_st_r <= ST_FOUND;
            state_r  <= S_RESP;
          end else if (pcnt_nxt == PROBE_MAX) begin
            res_idx_r <= '0;
            res_st_r  <= ST_OVERFLOW;
            state_r   <= S_RESP;
          end else begin
            pcnt_r  <= pcnt_nxt;
            slot_r  <= u_res[IDX_W-1:0];
            state_r <= S_PROBE;
          end
        end

        // append the name, or flag a full store
        S_INSERT: begin
          if (full) begin
            res_idx_r <= '0;
            res_st_r  <= ST_OVERFLOW;
          end else begin
            res_idx_r <= nfree_r;
            res_st_r  <= ST_INSERTED;
            nfree_r   <= nfree_r + 1'b1;
          end
          state_r <= S_RESP;
        end

        // hand the result to the output register when it is free
        S_RESP: begin
          if (!out_tvalid_r || out_tready) begin
            out_tvalid_r <= 1'b1;
            out_tdata_r  <= {4'b0000, res_st_r, res_idx_ext[ENTRY_W-1:0]};
            state_r      <= S_IDLE;
          end
        end

        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

endmodule

// ===== tb/symbol_table_checker.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// symbol_table_checker - result checker for the symbol lookup/insert block
// Watches both stream channels. Each name beat taken by the block is resolved
// against a local copy of the bucket table and the name store, and the
// expected entry index and status are queued. Each result beat is compared
// field by field with the oldest queued answer.
// ---------------------------------------------------------------------------
module symbol_table_checker
  import shli_pkg::*;
#(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [63:0] in_tdata,
  input  logic [0:0]  in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [15:0] out_tdata,
  output int          fail_count,
  output int          pending_count
);

  localparam int LINK_W = $clog2(TABLE_DEPTH) + 1;

  typedef struct packed {
    logic [ENTRY_W-1:0] entry;
    status_t            status;
  } table_answer_t;

  // Local copy of the table state: 0 in a bucket means empty, else entry + 1
  logic [LINK_W-1:0] bucket_link [TABLE_DEPTH];
  logic [NAME_W-1:0] stored_name [TABLE_DEPTH];
  int unsigned       names_used;
  table_answer_t     expected_answers [$];
  int                errs = 0;

  // Zero every byte from the terminating zero byte on
  function automatic logic [NAME_W-1:0] canonical_name(input logic [NAME_W-1:0] raw);
    logic [NAME_W-1:0] nm;
    int                len;
    nm  = raw;
    len = 0;
    while (len < 8 && raw[8*len +: 8] != 8'h00) len++;
    for (int i = len; i < 8; i++) nm[8*i +: 8] = 8'h00;
    return nm;
  endfunction

  // First bucket of the probe sequence for a name
  function automatic int unsigned home_bucket(input logic [NAME_W-1:0] nm);
    int unsigned b [8];
    int unsigned mixed;
    for (int i = 0; i < 8; i++) b[i] = nm[8*i +: 8];
    mixed = ((b[0] + b[3]) << 3) | (b[1] ^ b[7]) | ((b[2] ^ b[4] ^ b[5]) << 1)
          | (b[6] << 2);
    return ((HASH_MUL * mixed + HASH_ADD) & ((1 << HASH_W) - 1)) % TABLE_DEPTH;
  endfunction

  // Look a name up, append it when absent, and give the block's answer
  function automatic table_answer_t resolve_symbol(input logic [NAME_W-1:0] raw,
                                                   input logic temp);
    logic [NAME_W-1:0] nm;
    int unsigned       probe;
    int unsigned       slot;
    int unsigned       e;
    bit                have_slot;
    table_answer_t     ans;
    nm          = canonical_name(raw);
    have_slot   = 1'b0;
    slot        = 0;
    ans.entry   = '0;
    ans.status  = ST_OVERFLOW;
    if (!temp) begin
      probe = home_bucket(nm);
      for (int n = 0; n < TABLE_DEPTH && !have_slot; n++) begin
        if (bucket_link[probe] == '0) begin
          slot      = probe;
          have_slot = 1'b1;
        end else begin
          e = (bucket_link[probe] - 1) % TABLE_DEPTH;
          if (stored_name[e] == nm) begin
            ans.entry  = e[ENTRY_W-1:0];
            ans.status = ST_FOUND;
            return ans;
          end
          probe = (probe + PROBE_STRIDE) % TABLE_DEPTH;
        end
      end
      // every bucket visited without a hit or a hole
      if (!have_slot) return ans;
    end
    // store full: nothing is added
    if (names_used >= TABLE_DEPTH - 1) return ans;
    e              = names_used;
    stored_name[e] = nm;
    names_used     = e + 1;
    if (!temp) bucket_link[slot] = names_used[LINK_W-1:0];
    ans.entry  = e[ENTRY_W-1:0];
    ans.status = ST_INSERTED;
    return ans;
  endfunction

  // Predict on every name beat, compare on every result beat
  always @(posedge clk) begin : watch
    table_answer_t want;
    if (!rst_n) begin
      for (int i = 0; i < TABLE_DEPTH; i++) bucket_link[i] = '0;
      names_used = 0;
      expected_answers.delete();
    end else begin
      if (in_tvalid && in_tready) begin
        expected_answers.push_back(resolve_symbol(in_tdata, in_tuser[0]));
      end
      if (out_tvalid && out_tready) begin
        if (expected_answers.size() == 0) begin
          $error("result beat with no lookup pending: tdata %h", out_tdata);
          errs++;
        end else begin
          want = expected_answers.pop_front();
          if (out_tdata[9:0] != want.entry) begin
            $error("entry_index mismatch: expected %0d, got %0d",
                   want.entry, out_tdata[9:0]);
            errs++;
          end
          if (out_tdata[11:10] != want.status) begin
            $error("status mismatch: expected %0d, got %0d",
                   want.status, out_tdata[11:10]);
            errs++;
          end
          if (out_tdata[15:12] != 4'h0) begin
            $error("pad mismatch: expected 0, got %0d", out_tdata[15:12]);
            errs++;
          end
        end
      end
    end
    fail_count    <= errs;
    pending_count <= expected_answers.size();
  end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_top - testbench for the symbol hash lookup/insert block
// Sends a directed set of names (empty, full-width, bytes past the
// terminator, temporaries, colliding hashes), then random streams of new
// names, repeats, temporaries and noise, enough to overflow the name store.
// Both channels stall at random in shifting proportions; the checker
// predicts and compares every result.
// ---------------------------------------------------------------------------
module tb_top;

  localparam int RANDOM_ITEMS = 1600;
  localparam int DRAIN_CYCLES = 16;
  // random item mix, cumulative percent
  localparam int NEW_LIMIT    = 40;
  localparam int REPEAT_LIMIT = 67;
  localparam int TEMP_LIMIT   = 95;

  typedef struct {
    logic [63:0] nm;
    int          len;
  } known_name_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [63:0] in_tdata;
  logic [0:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;
  int          fail_count;
  int          pending_count;
  int          tx_idle_pct;
  int          rx_idle_pct;
  known_name_t known_names [$];

  symbol_hash_lookup_insert_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  symbol_table_checker checker_i (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .in_tuser     (in_tuser),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .fail_count   (fail_count),
    .pending_count(pending_count)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Stall the result channel at random
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= rx_idle_pct);
  end

  // Drive one name beat, with random idle cycles ahead of it
  task automatic send_name(input logic [63:0] nm, input logic temp);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= nm;
    in_tuser  <= temp;
    do @(posedge clk); while (!in_tready);
  endtask

  // Name of len nonzero bytes, zero above
  function automatic logic [63:0] random_name(input int len);
    logic [63:0] nm;
    nm = '0;
    for (int i = 0; i < len; i++) nm[8*i +: 8] = 8'($urandom_range(255, 1));
    return nm;
  endfunction

  // Fill the bytes past the terminator with junk the block must ignore
  function automatic logic [63:0] pad_garbage(input logic [63:0] nm, input int len);
    logic [63:0] res;
    res = nm;
    for (int i = len + 1; i < 8; i++) res[8*i +: 8] = 8'($urandom);
    return res;
  endfunction

  initial begin
    logic [63:0] body;
    int          len;
    int          pick;
    known_name_t entry;
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tuser    = '0;
    out_tready  = 1'b0;
    tx_idle_pct = 33;
    rx_idle_pct = 68;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // empty and full-width names, then repeats
    send_name(64'h0, 1'b0);
    send_name(64'h0, 1'b0);
    send_name('1, 1'b0);
    send_name('1, 1'b0);
    // bytes past a leading zero byte are dropped: both are the empty name
    send_name(64'hFFFF_FFFF_FFFF_FF00, 1'b0);
    send_name(64'h8000_0000_0000_0000, 1'b0);
    // short name with junk past the terminator, then the clean form
    send_name(64'hDEAD_BEEF_C000_4241, 1'b0);
    send_name(64'h0000_0000_0000_4241, 1'b0);
    // temporaries always append, even when the name is present
    send_name(64'h0000_0000_0000_4241, 1'b1);
    send_name(64'h0, 1'b1);
    send_name('1, 1'b1);
    // four names with one hash: probe chain, then hits deep in it
    send_name(64'h0807_0605_0403_0201, 1'b0);
    send_name(64'h0207_0605_0403_0801, 1'b0);
    send_name(64'h0807_0605_0103_0204, 1'b0);
    send_name(64'h0807_0603_0505_0201, 1'b0);
    send_name(64'h0807_0605_0103_0204, 1'b0);
    send_name(64'h0807_0603_0505_0201, 1'b0);
    send_name(64'h0807_0605_0403_0201, 1'b0);
    send_name(64'h0207_0605_0403_0801, 1'b0);
    send_name(64'h7F7F_7F7F_7F7F_7F7F, 1'b0);
    send_name(64'h0101_0101_0101_0101, 1'b0);

    // random mix: enough appends to fill the store and then overflow
    for (int k = 0; k < RANDOM_ITEMS; k++) begin
      if (k == RANDOM_ITEMS / 3) begin
        tx_idle_pct = 68;
        rx_idle_pct = 33;
      end else if (k == 2 * RANDOM_ITEMS / 3) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      pick = $urandom_range(99);
      if (pick < NEW_LIMIT || known_names.size() == 0) begin
        len       = $urandom_range(8, 1);
        body      = random_name(len);
        entry.nm  = body;
        entry.len = len;
        known_names.push_back(entry);
        send_name($urandom_range(1) ? pad_garbage(body, len) : body, 1'b0);
      end else if (pick < REPEAT_LIMIT) begin
        entry = known_names[$urandom_range(known_names.size() - 1)];
        send_name($urandom_range(1) ? pad_garbage(entry.nm, entry.len) : entry.nm,
                  1'b0);
      end else if (pick < TEMP_LIMIT) begin
        len  = $urandom_range(8, 0);
        body = random_name(len);
        send_name($urandom_range(1) ? pad_garbage(body, len) : body, 1'b1);
      end else begin
        send_name({$urandom, $urandom}, 1'($urandom_range(1)));
      end
    end
    in_tvalid <= 1'b0;

    // drain outstanding results, then let the block settle
    do @(posedge clk); while (pending_count != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASS symbol_hash_lookup_insert_top");
    end else begin
      $display("FAIL symbol_hash_lookup_insert_top");
    end
    $finish;
  end

  // Hang guard
  initial begin
    #200_000_000;
    $display("FAIL symbol_hash_lookup_insert_top");
    $finish;
  end

endmodule
